FILE: rtl/core/tlv_stream_parser_assert.svh
// Assertion macros used by the checker of the TLV stream parser.
// Needs clk and arst_n in the scope of each use.
`ifndef TLV_STREAM_PARSER_ASSERT_SVH
`define TLV_STREAM_PARSER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TSP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define TSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/tsp_pkg.sv
// Types and constants of the TLV stream parser.
// No dependencies; imported by every module of the block.
package tsp_pkg;

	localparam logic [12:0] MAX_ENTRY_CAP = 13'd4096;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] REG_TAG_SIZE    = 3'd0;
	localparam logic [2:0] REG_LENGTH_SIZE = 3'd1;
	localparam logic [2:0] REG_PAD_ENABLE  = 3'd2;
	localparam logic [2:0] REG_END_ENABLE  = 3'd3;
	localparam logic [2:0] REG_PAD_TAG     = 3'd4;
	localparam logic [2:0] REG_END_TAG     = 3'd5;
	localparam logic [2:0] REG_MAX_ENTRIES = 3'd6;

	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_EMPTY  = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TRUNCATED = 2'd1;
	localparam logic [1:0] ST_TOO_MANY  = 2'd2;

	localparam logic [1:0] SIZE_ONE = 2'd0;
	localparam logic [1:0] SIZE_TWO = 2'd1;

	localparam logic CMD_BYTE  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef enum logic [3:0] {
		PH_TAG  = 4'b0001,
		PH_LEN  = 4'b0010,
		PH_PAY  = 4'b0100,
		PH_SKIP = 4'b1000
	} phase_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] in_byte;
		logic       msg_last;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] entry_tag;
		logic [31:0] entry_length;
		logic [7:0]  payload_byte;
		logic        entry_byte_last;
		logic [11:0] entry_number;
		logic [1:0]  status;
		logic        run_last;
	} rsp_t;

	typedef struct packed {
		logic [1:0] count;
		rsp_t       first;
		rsp_t       second;
	} push_t;

endpackage

FILE: rtl/core/tsp_out_fifo.sv
// Result queue of the TLV stream parser: takes up to two results a cycle.
// Depends on tsp_pkg.
module tsp_out_fifo
	import tsp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	output logic  rsp_valid,
	input  logic  rsp_stall,
	output rsp_t  rsp_data
);

	rsp_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              pop;
	logic [QPTR_W-1:0] wr_nxt;

	assign rsp_valid = (cnt_q != '0);
	assign rsp_data  = mem_q[rd_q];
	assign pop       = rsp_valid && !rsp_stall;
	assign room      = (cnt_q <= QCNT_W'(QUEUE_DEPTH - 2));
	assign wr_nxt    = wr_q + QPTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_nxt] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(push.count);
			rd_q  <= rd_q + QPTR_W'(pop);
			cnt_q <= cnt_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

endmodule

FILE: rtl/core/tlv_stream_parser.sv
// A result is written into the result queue and offered from there.
// Throughput: one request per cycle; a request can give two results, and the
// four-entry result queue stalls requests while it holds more than two.
// Reset clears the header state, entry count, error and queue, and sets the registers to their defaults.
// Depends on tsp_pkg and tsp_out_fifo.
module tlv_stream_parser
	import tsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	logic [1:0]  tag_size_q, length_size_q;
	logic        pad_enable_q, end_enable_q;
	logic [7:0]  pad_tag_q, end_tag_q;
	logic [12:0] max_entries_q;

	phase_t      phase_q, phase_d;
	logic [1:0]  fbc_q, fbc_d;
	logic [31:0] hdr_q, hdr_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] rem_q, rem_d;
	logic [12:0] cnt_q, cnt_d;
	logic [1:0]  err_q, err_d;

	logic        accept, room;
	logic [1:0]  size_code;
	logic [2:0]  need, cnt3;
	logic        field_done;
	logic [31:0] hdr_new, rem_dec;
	logic [12:0] cap;
	logic [1:0]  st;
	push_t       push;

	assign req_stall = !room;
	assign accept    = req_valid && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_size_q    <= SIZE_ONE;
			length_size_q <= SIZE_ONE;
			pad_enable_q  <= 1'b0;
			end_enable_q  <= 1'b0;
			pad_tag_q     <= 8'd0;
			end_tag_q     <= 8'd255;
			max_entries_q <= 13'd4096;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TAG_SIZE:    tag_size_q    <= cfg_data[1:0];
				REG_LENGTH_SIZE: length_size_q <= cfg_data[1:0];
				REG_PAD_ENABLE:  pad_enable_q  <= cfg_data[0];
				REG_END_ENABLE:  end_enable_q  <= cfg_data[0];
				REG_PAD_TAG:     pad_tag_q     <= cfg_data[7:0];
				REG_END_TAG:     end_tag_q     <= cfg_data[7:0];
				REG_MAX_ENTRIES: max_entries_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign size_code  = (phase_q == PH_TAG) ? tag_size_q : length_size_q;
	assign need       = (size_code == SIZE_ONE) ? 3'd1 : (size_code == SIZE_TWO) ? 3'd2 : 3'd4;
	assign cnt3       = {1'b0, fbc_q} + 3'd1;
	assign field_done = (cnt3 >= need);
	assign hdr_new    = (fbc_q == 2'd0) ? {24'd0, req_data.in_byte}
	                                    : {hdr_q[23:0], req_data.in_byte};
	assign rem_dec    = rem_q - 32'd1;
	assign cap        = (max_entries_q > MAX_ENTRY_CAP) ? MAX_ENTRY_CAP : max_entries_q;

	always_comb begin
		phase_d = phase_q;
		fbc_d   = fbc_q;
		hdr_d   = hdr_q;
		tag_d   = tag_q;
		rem_d   = rem_q;
		cnt_d   = cnt_q;
		err_d   = err_q;
		st      = ST_OK;
		push    = '0;
		if (req_data.cmd == CMD_CLEAR) begin
			cnt_d = '0;
		end else begin
			case (phase_q)
				PH_TAG, PH_LEN: begin
					hdr_d = hdr_new;
					if (!field_done) begin
						fbc_d = cnt3[1:0];
					end else begin
						fbc_d = 2'd0;
						if (phase_q == PH_TAG) begin
							tag_d = hdr_new;
							if (pad_enable_q && hdr_new == {24'd0, pad_tag_q}) begin
								phase_d = PH_TAG;
							end else if (end_enable_q && hdr_new == {24'd0, end_tag_q}) begin
								phase_d = PH_SKIP;
							end else begin
								phase_d = PH_LEN;
							end
						end else if (cnt_q >= cap) begin
							err_d   = ST_TOO_MANY;
							phase_d = PH_SKIP;
						end else if (hdr_new == 32'd0) begin
							push.count              = 2'd1;
							push.first.kind         = KIND_EMPTY;
							push.first.entry_tag    = tag_q;
							push.first.entry_number = cnt_q[11:0];
							cnt_d                   = cnt_q + 13'd1;
							phase_d                 = PH_TAG;
						end else begin
							rem_d   = hdr_new;
							phase_d = PH_PAY;
						end
					end
				end
				PH_PAY: begin
					rem_d                      = rem_dec;
					push.count                 = 2'd1;
					push.first.kind            = KIND_BYTE;
					push.first.entry_tag       = tag_q;
					push.first.entry_length    = hdr_q;
					push.first.payload_byte    = req_data.in_byte;
					push.first.entry_byte_last = (rem_dec == 32'd0);
					push.first.entry_number    = cnt_q[11:0];
					if (rem_dec == 32'd0) begin
						cnt_d   = cnt_q + 13'd1;
						phase_d = PH_TAG;
					end
				end
				default: ;
			endcase
			if (req_data.msg_last) begin
				if (err_d != ST_OK) begin
					st = err_d;
				end else if (phase_d == PH_SKIP) begin
					st = ST_OK;
				end else if (phase_d == PH_TAG && fbc_d == 2'd0) begin
					st = ST_OK;
				end else begin
					st = ST_TRUNCATED;
				end
				if (push.count == 2'd1) begin
					push.count          = 2'd2;
					push.second.kind    = KIND_STATUS;
					push.second.status  = st;
					push.second.run_last = 1'b1;
				end else begin
					push.count          = 2'd1;
					push.first.kind     = KIND_STATUS;
					push.first.status   = st;
					push.first.run_last = 1'b1;
				end
				phase_d = PH_TAG;
				fbc_d   = 2'd0;
				rem_d   = 32'd0;
				err_d   = ST_OK;
			end else if (push.count == 2'd1) begin
				push.first.run_last = 1'b1;
			end
		end
		if (!accept) begin
			push.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			fbc_q   <= '0;
			hdr_q   <= '0;
			tag_q   <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
			err_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			fbc_q   <= fbc_d;
			hdr_q   <= hdr_d;
			tag_q   <= tag_d;
			rem_q   <= rem_d;
			cnt_q   <= cnt_d;
			err_q   <= err_d;
		end
	end

	tsp_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule

FILE: rtl/core/tsp_checker.sv
// Port checker of the TLV stream parser and its bind to the top level.
// Depends on tsp_pkg and tlv_stream_parser_assert.svh.
`include "tlv_stream_parser_assert.svh"

module tsp_checker
	import tsp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp_data
);

	`TSP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")
	`TSP_ASSERT_NOW(a_status_clean, rsp_valid && rsp_data.kind == KIND_STATUS, rsp_data.entry_tag == 32'd0 && rsp_data.entry_length == 32'd0 && rsp_data.entry_number == 12'd0 && rsp_data.run_last, "status result carries entry fields")
	`TSP_ASSERT_NOW(a_status_only_end, rsp_valid && rsp_data.kind != KIND_STATUS, rsp_data.status == ST_OK, "status set on entry result")
	`TSP_ASSERT_NOW(a_kind_legal, rsp_valid, rsp_data.kind == KIND_BYTE || rsp_data.kind == KIND_EMPTY || rsp_data.kind == KIND_STATUS, "illegal result kind")

endmodule

bind tlv_stream_parser tsp_checker u_tsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_data  (rsp_data)
);
